>>> hw/rtl/pst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg
// shared types and constants for the prime sieve and test engine
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int SieveAw   = 14;             // sieve store address bits
    localparam int TableAw   = 10;             // prime table address bits
    localparam int CountW    = TableAw + 1;
    localparam int NumW      = 24;
    localparam int PrimeW    = 14;
    localparam int RemW      = PrimeW;
    localparam int DivCntW   = 5;              // counts the 24 division steps
    localparam logic [SieveAw-1:0] LimitMax   = '1;
    localparam logic [SieveAw-1:0] LimitReset = 14'd10000;
    localparam logic [CountW-1:0]  TableFull  = 11'd1024;

    typedef enum logic [1:0] {
        CMD_BUILD = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TEST  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the transaction operands
        logic fill_set;    // sieve: write mark 1 at the sweep pointer
        logic outer_rd;    // sieve: read mark of the outer index
        logic outer_next;  // sieve: advance outer index
        logic inner_init;  // sieve: inner pointer = i*i
        logic inner_clr;   // sieve: clear mark at inner pointer, step by i
        logic coll_rd;     // collect: read mark at sweep pointer
        logic coll_wr;     // collect: store prime if marked, advance
        logic sweep_init;  // reset sweep pointer to two
        logic tab_rd;      // table read at index or test pointer
        logic div_init;    // start a remainder computation
        logic div_step;    // one restoring division step
        logic div_next;    // advance to next table prime
        logic count_clr;   // clear stored count
    } t_ctl;

    // status from datapath to controller
    typedef struct packed {
        logic fill_done;   // sweep pointer passed the limit
        logic outer_done;  // i*i beyond limit
        logic outer_mark;  // mark of i (registered read)
        logic inner_done;  // inner pointer beyond limit
        logic coll_done;   // collect finished
        logic div_last;    // last division step
        logic tab_end;     // test pointer reached stored count
        logic p_stop;      // p*p > n
        logic rem_zero;    // remainder zero
        logic small_num;   // n below two
    } t_sts;

endpackage

>>> hw/rtl/prime_sieve_and_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_sieve_and_test
// sieve of eratosthenes prime table with read and trial-division test
// ----------------------------------------------------------------------------
// usage: a transaction is taken when start is high and busy is low; cmd
// 0 builds the table from the sieve up to i_sieve_limit, 1 reads table
// entry i_table_index, 2 tests i_test_number, 3 only reports the count.
// the single result appears for one cycle with o_done high; the receiver
// cannot stall it. busy stays high through the o_done cycle.
// build fills the sieve up to the limit, checks each outer index up to
// sqrt(limit), strikes its multiples and collects the primes (stopping
// once the table is full); test tries table primes with the 24-step
// serial remainder unit, one dividend bit per cycle, bounded by the
// primes up to sqrt(n). one transaction is in flight at a time.
// reset: sieve limit returns to 10000 and the stored count to zero; the
// sieve and table memories are not cleared and hold no meaning until a
// build has written them. i_sieve_limit_we may be used only while idle.
// ----------------------------------------------------------------------------
module prime_sieve_and_test (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_sieve_limit_we,
    input  logic [pst_pkg::SieveAw-1:0]   i_sieve_limit,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic [pst_pkg::TableAw-1:0]   i_table_index,
    input  logic [pst_pkg::NumW-1:0]      i_test_number,
    output logic                          o_done,
    output logic [pst_pkg::PrimeW-1:0]    o_prime_value,
    output logic [pst_pkg::CountW-1:0]    o_count_of_primes,
    output logic                          o_number_is_prime,
    output logic                          o_index_in_range
);

    pst_pkg::t_ctl                 ctl;
    pst_pkg::t_sts                 sts;
    logic [pst_pkg::PrimeW-1:0]    tab_q;
    logic [pst_pkg::CountW-1:0]    count;
    logic                          index_ok;
    logic                          is_read;
    logic                          verdict;
    logic                          rd_ok;

    // controller
    pst_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (i_cmd),
        .i_sts        (sts),
        .o_ctl        (ctl),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_is_read    (is_read),
        .o_prime_flag (verdict)
    );

    // datapath
    pst_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_sieve_limit_we),
        .i_cfg_data    (i_sieve_limit),
        .i_table_index (i_table_index),
        .i_test_number (i_test_number),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .o_tab_q       (tab_q),
        .o_count       (count),
        .o_index_ok    (index_ok)
    );

    // result fields
    assign rd_ok             = is_read & index_ok;
    assign o_prime_value     = rd_ok ? tab_q : '0;
    assign o_index_in_range  = rd_ok;
    assign o_count_of_primes = count;
    assign o_number_is_prime = verdict;

endmodule

>>> hw/rtl/pst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_datapath
// sieve store, prime table, pointers and the serial remainder unit
// ----------------------------------------------------------------------------
module pst_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pst_pkg::SieveAw-1:0]   i_cfg_data,
    input  logic [pst_pkg::TableAw-1:0]   i_table_index,
    input  logic [pst_pkg::NumW-1:0]      i_test_number,
    input  pst_pkg::t_ctl                 i_ctl,
    output pst_pkg::t_sts                 o_sts,
    output logic [pst_pkg::PrimeW-1:0]    o_tab_q,
    output logic [pst_pkg::CountW-1:0]    o_count,
    output logic                          o_index_ok
);

    localparam int Sw = pst_pkg::SieveAw;
    localparam int Tw = pst_pkg::TableAw;
    localparam int Cw = pst_pkg::CountW;
    localparam int Nw = pst_pkg::NumW;
    localparam int Pw = pst_pkg::PrimeW;
    localparam int Rw = pst_pkg::RemW;

    // memories
    logic                r_marks [2**Sw];
    logic [Pw-1:0]       r_table [2**Tw];
    logic                r_mark_q;
    logic [Pw-1:0]       r_tab_q;

    logic [Sw-1:0]       r_limit;
    logic [Cw-1:0]       r_count;
    logic [Tw-1:0]       r_index;
    logic [Nw-1:0]       r_num;
    logic [Sw:0]         r_sweep;      // fill and collect pointer
    logic [Sw:0]         r_outer;      // outer sieve index
    logic [2*Sw+1:0]     r_outer_sq;   // i*i (registered)
    logic [2*Sw+1:0]     r_inner;      // inner pointer
    logic [Cw-1:0]       r_tptr;       // test pointer
    logic [Rw:0]         r_rem;
    logic [Nw-1:0]       r_dvd;
    logic [pst_pkg::DivCntW-1:0] r_dcnt;

    logic [Sw-1:0]       lim_eff;
    logic [Rw:0]         rem_sh;
    logic [Rw+1:0]       rem_sub;
    logic [2*Pw-1:0]     tab_sq;

    // effective limit: the register already fits the store
    assign lim_eff = r_limit;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= pst_pkg::LimitReset;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // operand capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_index <= i_table_index;
            r_num   <= i_test_number;
        end
    end

    // sieve store: one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.fill_set) begin
            r_marks[r_sweep[Sw-1:0]] <= 1'b1;
        end else if (i_ctl.inner_clr) begin
            r_marks[r_inner[Sw-1:0]] <= 1'b0;
        end
        if (i_ctl.outer_rd) begin
            r_mark_q <= r_marks[r_outer[Sw-1:0]];
        end else if (i_ctl.coll_rd) begin
            r_mark_q <= r_marks[r_sweep[Sw-1:0]];
        end
    end

    // sweep pointer for fill and collect
    always_ff @(posedge i_clk) begin
        if (i_ctl.sweep_init) begin
            r_sweep <= (Sw+1)'(2);
        end else if (i_ctl.fill_set || i_ctl.coll_wr) begin
            r_sweep <= r_sweep + (Sw+1)'(1);
        end
    end

    // outer index and its square
    always_ff @(posedge i_clk) begin
        if (i_ctl.sweep_init) begin
            r_outer    <= (Sw+1)'(2);
            r_outer_sq <= (2*Sw+2)'(4);
        end else if (i_ctl.outer_next) begin
            r_outer    <= r_outer + (Sw+1)'(1);
            r_outer_sq <= r_outer_sq + (2*Sw+2)'({r_outer, 1'b1});
        end
    end

    // inner pointer
    always_ff @(posedge i_clk) begin
        if (i_ctl.inner_init) begin
            r_inner <= r_outer_sq;
        end else if (i_ctl.inner_clr) begin
            r_inner <= r_inner + (2*Sw+2)'(r_outer);
        end
    end

    // stored count and table writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.count_clr) begin
            r_count <= '0;
        end else if (i_ctl.coll_wr && r_mark_q) begin
            r_count <= r_count + Cw'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.coll_wr && r_mark_q) begin
            r_table[r_count[Tw-1:0]] <= r_sweep[Pw-1:0];
        end
        if (i_ctl.tab_rd) begin
            r_tab_q <= r_table[i_ctl.load ? i_table_index : r_tptr[Tw-1:0]];
        end
    end

    // test pointer
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_tptr <= '0;
        end else if (i_ctl.div_next) begin
            r_tptr <= r_tptr + Cw'(1);
        end
    end

    // restoring division, one dividend bit per cycle
    assign rem_sh  = {r_rem[Rw-1:0], r_dvd[Nw-1]};
    assign rem_sub = {1'b0, rem_sh} - {2'b00, r_tab_q};

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_init) begin
            r_rem  <= '0;
            r_dvd  <= r_num;
            r_dcnt <= '0;
        end else if (i_ctl.div_step) begin
            r_rem  <= rem_sub[Rw+1] ? rem_sh : rem_sub[Rw:0];
            r_dvd  <= {r_dvd[Nw-2:0], 1'b0};
            r_dcnt <= r_dcnt + pst_pkg::DivCntW'(1);
        end
    end

    // square of the table prime just read
    assign tab_sq = r_tab_q * r_tab_q;

    // status
    always_comb begin
        o_sts            = '0;
        o_sts.fill_done  = r_sweep > (Sw+1)'(lim_eff);
        o_sts.outer_done = r_outer_sq > (2*Sw+2)'(lim_eff);
        o_sts.outer_mark = r_mark_q;
        o_sts.inner_done = r_inner > (2*Sw+2)'(lim_eff);
        o_sts.coll_done  = (r_sweep > (Sw+1)'(lim_eff)) || (r_count == pst_pkg::TableFull);
        o_sts.div_last   = r_dcnt == pst_pkg::DivCntW'(Nw - 1);
        o_sts.tab_end    = r_tptr == r_count;
        o_sts.p_stop     = (r_tab_q == '0) || (tab_sq > (2*Pw)'(r_num));
        o_sts.rem_zero   = r_rem == '0;
        o_sts.small_num  = r_num < Nw'(2);
    end

    assign o_tab_q    = r_tab_q;
    assign o_count    = r_count;
    assign o_index_ok = Cw'(r_index) < r_count;

endmodule

>>> hw/rtl/pst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_ctrl
// command sequencer for build, read, test and no-op
// ----------------------------------------------------------------------------
module pst_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_cmd,
    input  pst_pkg::t_sts       i_sts,
    output pst_pkg::t_ctl       o_ctl,
    output logic                o_busy,
    output logic                o_done,
    output logic                o_is_read,
    output logic                o_prime_flag
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_FILL   = 14'b00000000000010,
        S_ORD    = 14'b00000000000100,
        S_OCHK   = 14'b00000000001000,
        S_INNER  = 14'b00000000010000,
        S_CRD    = 14'b00000000100000,
        S_CWR    = 14'b00000001000000,
        S_RWAIT  = 14'b00000010000000,
        S_TRD    = 14'b00000100000000,
        S_TCHK   = 14'b00001000000000,
        S_DIV    = 14'b00010000000000,
        S_DCHK   = 14'b00100000000000,
        S_DONE   = 14'b01000000000000,
        S_TSTART = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_read, n_read;
    logic   r_prime, n_prime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_read  <= 1'b0;
            r_prime <= 1'b0;
        end else begin
            r_state <= n_state;
            r_read  <= n_read;
            r_prime <= n_prime;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_read  = r_read;
        n_prime = r_prime;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_read     = 1'b0;
                    n_prime    = 1'b0;
                    unique case (pst_pkg::t_cmd'(i_cmd))
                        pst_pkg::CMD_BUILD: begin
                            o_ctl.sweep_init = 1'b1;
                            o_ctl.count_clr  = 1'b1;
                            n_state          = S_FILL;
                        end
                        pst_pkg::CMD_READ: begin
                            o_ctl.tab_rd = 1'b1;
                            n_read       = 1'b1;
                            n_state      = S_RWAIT;
                        end
                        pst_pkg::CMD_TEST: n_state = S_TSTART;
                        default:           n_state = S_DONE;
                    endcase
                end
            end
            // mark 2..limit
            S_FILL: begin
                if (i_sts.fill_done) begin
                    o_ctl.sweep_init = 1'b1;
                    n_state          = S_ORD;
                end else begin
                    o_ctl.fill_set = 1'b1;
                end
            end
            // outer sieve loop
            S_ORD: begin
                if (i_sts.outer_done) begin
                    o_ctl.sweep_init = 1'b1;
                    n_state          = S_CRD;
                end else begin
                    o_ctl.outer_rd   = 1'b1;
                    o_ctl.inner_init = 1'b1;
                    n_state          = S_OCHK;
                end
            end
            S_OCHK: begin
                if (i_sts.outer_mark) begin
                    n_state = S_INNER;
                end else begin
                    o_ctl.outer_next = 1'b1;
                    n_state          = S_ORD;
                end
            end
            S_INNER: begin
                if (i_sts.inner_done) begin
                    o_ctl.outer_next = 1'b1;
                    n_state          = S_ORD;
                end else begin
                    o_ctl.inner_clr = 1'b1;
                end
            end
            // collect primes into the table
            S_CRD: begin
                if (i_sts.coll_done) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.coll_rd = 1'b1;
                    n_state       = S_CWR;
                end
            end
            S_CWR: begin
                o_ctl.coll_wr = 1'b1;
                n_state       = S_CRD;
            end
            S_RWAIT: n_state = S_DONE;
            // trial division
            S_TSTART: begin
                if (i_sts.small_num) begin
                    n_state = S_DONE;
                end else begin
                    n_prime = 1'b1;
                    n_state = S_TRD;
                end
            end
            S_TRD: begin
                if (i_sts.tab_end) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.tab_rd = 1'b1;
                    n_state      = S_TCHK;
                end
            end
            S_TCHK: begin
                if (i_sts.p_stop) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                if (i_sts.rem_zero) begin
                    n_prime = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_ctl.div_next = 1'b1;
                    n_state        = S_TRD;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // status outputs
    assign o_busy       = r_state != S_IDLE;
    assign o_done       = r_state == S_DONE;
    assign o_is_read    = r_read;
    assign o_prime_flag = r_prime;

endmodule

>>> test/prime_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_engine_checker
// watches the command and result channels of the prime engine, keeps its own
// sieve, prime table and count, and compares every result with its forecast
// ----------------------------------------------------------------------------
module prime_engine_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_sieve_limit_we,
    input  logic [pst_pkg::SieveAw-1:0]   i_sieve_limit,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [1:0]                    i_cmd,
    input  logic [pst_pkg::TableAw-1:0]   i_table_index,
    input  logic [pst_pkg::NumW-1:0]      i_test_number,
    input  logic                          i_done,
    input  logic [pst_pkg::PrimeW-1:0]    i_prime_value,
    input  logic [pst_pkg::CountW-1:0]    i_count_of_primes,
    input  logic                          i_number_is_prime,
    input  logic                          i_index_in_range,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int SieveDepth = 1 << pst_pkg::SieveAw;
    localparam int TableDepth = 1 << pst_pkg::TableAw;

    typedef struct {
        logic [pst_pkg::PrimeW-1:0] prime_value;
        logic [pst_pkg::CountW-1:0] count;
        logic                       prime_flag;
        logic                       in_range;
    } t_answer;

    bit                          mark_mem [SieveDepth];
    logic [pst_pkg::PrimeW-1:0]  prime_mem [TableDepth];
    logic [pst_pkg::CountW-1:0]  table_cnt;
    logic [pst_pkg::SieveAw-1:0] limit_reg;
    t_answer                     answer_q [$];
    int                          fails;

    assign o_fail_count = fails;
    assign o_pending    = answer_q.size();

    // sieve up to the limit, then collect primes until the table is full
    task automatic run_sieve();
        int lim;
        lim = limit_reg;
        for (int i = 0; i < SieveDepth; i++) mark_mem[i] = (i >= 2 && i <= lim);
        for (int i = 2; i * i <= lim; i++) begin
            if (mark_mem[i]) begin
                for (int j = i * i; j <= lim; j += i) mark_mem[j] = 0;
            end
        end
        table_cnt = '0;
        for (int i = 2; i <= lim && table_cnt < pst_pkg::TableFull; i++) begin
            if (mark_mem[i]) begin
                prime_mem[table_cnt] = pst_pkg::PrimeW'(i);
                table_cnt++;
            end
        end
    endtask

    // trial division with table primes while p*p <= n
    function automatic logic judge_prime(logic [pst_pkg::NumW-1:0] n);
        longint p;
        if (n < 2) return 1'b0;
        for (int k = 0; k < table_cnt; k++) begin
            p = prime_mem[k];
            if (p == 0 || p * p > n) break;
            if (n % p == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // forecast on each accepted transaction, compare on each strobe
    always @(posedge i_clk) begin
        t_answer a;
        if (!i_rst_n) begin
            table_cnt = '0;
            limit_reg = pst_pkg::LimitReset;
            answer_q.delete();
            fails     = 0;
        end else begin
            if (i_sieve_limit_we) limit_reg = i_sieve_limit;
            if (i_done) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: result with no transaction pending", $time);
                    fails++;
                end else begin
                    a = answer_q.pop_front();
                    if (i_prime_value !== a.prime_value) begin
                        $display("%0t: prime_value exp %0d got %0d", $time,
                                 a.prime_value, i_prime_value);
                        fails++;
                    end
                    if (i_count_of_primes !== a.count) begin
                        $display("%0t: count_of_primes exp %0d got %0d", $time,
                                 a.count, i_count_of_primes);
                        fails++;
                    end
                    if (i_number_is_prime !== a.prime_flag) begin
                        $display("%0t: number_is_prime exp %0d got %0d", $time,
                                 a.prime_flag, i_number_is_prime);
                        fails++;
                    end
                    if (i_index_in_range !== a.in_range) begin
                        $display("%0t: index_in_range exp %0d got %0d", $time,
                                 a.in_range, i_index_in_range);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                a = '{default: '0};
                case (pst_pkg::t_cmd'(i_cmd))
                    pst_pkg::CMD_BUILD: run_sieve();
                    pst_pkg::CMD_READ: begin
                        if (i_table_index < table_cnt) begin
                            a.prime_value = prime_mem[i_table_index];
                            a.in_range    = 1'b1;
                        end
                    end
                    pst_pkg::CMD_TEST: a.prime_flag = judge_prime(i_test_number);
                    default: ;
                endcase
                a.count = table_cnt;
                answer_q.push_back(a);
            end
        end
    end

endmodule

>>> test/tb_prime_sieve_and_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prime_sieve_and_test
// drives build, read, test and no-op commands at several sieve limits, from
// the extremes to the reset value, with random sender gaps; a checker module
// beside the engine forecasts and compares every result
// ----------------------------------------------------------------------------
module tb_prime_sieve_and_test;

    localparam longint CycleLimit = 40_000_000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_sieve_limit_we;
    logic [pst_pkg::SieveAw-1:0]  i_sieve_limit;
    logic                         start;
    logic                         busy;
    logic [1:0]                   i_cmd;
    logic [pst_pkg::TableAw-1:0]  i_table_index;
    logic [pst_pkg::NumW-1:0]     i_test_number;
    logic                         o_done;
    logic [pst_pkg::PrimeW-1:0]   o_prime_value;
    logic [pst_pkg::CountW-1:0]   o_count_of_primes;
    logic                         o_number_is_prime;
    logic                         o_index_in_range;

    int                           fail_count;
    int                           pending;
    longint                       cycle_count = 0;
    logic [pst_pkg::CountW-1:0]   last_count = '0;
    int                           idle_pct;
    int                           cmd_tally [4];

    prime_sieve_and_test dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_sieve_limit_we  (i_sieve_limit_we),
        .i_sieve_limit     (i_sieve_limit),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_table_index     (i_table_index),
        .i_test_number     (i_test_number),
        .o_done            (o_done),
        .o_prime_value     (o_prime_value),
        .o_count_of_primes (o_count_of_primes),
        .o_number_is_prime (o_number_is_prime),
        .o_index_in_range  (o_index_in_range)
    );

    prime_engine_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_sieve_limit_we  (i_sieve_limit_we),
        .i_sieve_limit     (i_sieve_limit),
        .i_start           (start),
        .i_busy            (busy),
        .i_cmd             (i_cmd),
        .i_table_index     (i_table_index),
        .i_test_number     (i_test_number),
        .i_done            (o_done),
        .i_prime_value     (o_prime_value),
        .i_count_of_primes (o_count_of_primes),
        .i_number_is_prime (o_number_is_prime),
        .i_index_in_range  (o_index_in_range),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog and count tracking for read index choice
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (o_done) last_count <= o_count_of_primes;
        if (cycle_count > CycleLimit) begin
            $display("watchdog expired at cycle %0d", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one transaction, with an optional sender gap before it
    task automatic send_cmd(pst_pkg::t_cmd c, logic [pst_pkg::TableAw-1:0] idx,
                            logic [pst_pkg::NumW-1:0] n);
        bit taken;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= c;
        i_table_index <= idx;
        i_test_number <= n;
        cmd_tally[c]++;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // new sieve limit, only once the engine has drained
    task automatic set_limit(logic [pst_pkg::SieveAw-1:0] lim);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_sieve_limit_we <= 1'b1;
        i_sieve_limit    <= lim;
        @(posedge i_clk);
        i_sieve_limit_we <= 1'b0;
    endtask

    function automatic logic [pst_pkg::NumW-1:0] pick_number();
        case ($urandom_range(7))
            0: return pst_pkg::NumW'($urandom);
            1: return pst_pkg::NumW'($urandom_range(0, 4));
            2: return {pst_pkg::NumW{1'b1}} - pst_pkg::NumW'($urandom_range(0, 3));
            default: return pst_pkg::NumW'($urandom) >> $urandom_range(2, 22);
        endcase
    endfunction

    // random phase: build first, then a mix dominated by reads and tests
    task automatic run_phase(logic [pst_pkg::SieveAw-1:0] lim, int n_items);
        int r;
        set_limit(lim);
        send_cmd(pst_pkg::CMD_BUILD, pst_pkg::TableAw'($urandom), pick_number());
        for (int i = 1; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 4) begin
                send_cmd(pst_pkg::CMD_BUILD, pst_pkg::TableAw'($urandom), pick_number());
            end else if (r < 40) begin
                if (last_count != 0 && r < 32)
                    send_cmd(pst_pkg::CMD_READ,
                             pst_pkg::TableAw'($urandom_range(0, last_count - 1)),
                             pst_pkg::NumW'($urandom));
                else
                    send_cmd(pst_pkg::CMD_READ, pst_pkg::TableAw'($urandom),
                             pst_pkg::NumW'($urandom));
            end else if (r < 92) begin
                send_cmd(pst_pkg::CMD_TEST, pst_pkg::TableAw'($urandom), pick_number());
            end else begin
                send_cmd(pst_pkg::CMD_NOP, pst_pkg::TableAw'($urandom),
                         pst_pkg::NumW'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_sieve_limit_we = 1'b0;
        i_sieve_limit    = '0;
        start            = 1'b0;
        i_cmd            = pst_pkg::CMD_NOP;
        i_table_index    = '0;
        i_test_number    = '0;
        idle_pct         = 11;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, reset limit, table edges, number extremes
        send_cmd(pst_pkg::CMD_TEST, '0, 24'd97);
        send_cmd(pst_pkg::CMD_TEST, '0, 24'd1);
        send_cmd(pst_pkg::CMD_READ, '0, '0);
        send_cmd(pst_pkg::CMD_NOP, '1, '1);
        send_cmd(pst_pkg::CMD_BUILD, '0, '0);
        send_cmd(pst_pkg::CMD_READ, '0, '0);
        send_cmd(pst_pkg::CMD_READ, 10'd1022, '0);
        send_cmd(pst_pkg::CMD_READ, '1, '0);
        send_cmd(pst_pkg::CMD_TEST, '0, 24'd0);
        send_cmd(pst_pkg::CMD_TEST, '0, 24'd2);
        send_cmd(pst_pkg::CMD_TEST, '0, 24'd4);
        send_cmd(pst_pkg::CMD_TEST, '0, 24'd9);
        send_cmd(pst_pkg::CMD_TEST, '0, 24'd16777213);
        send_cmd(pst_pkg::CMD_TEST, '0, '1);
        send_cmd(pst_pkg::CMD_NOP, '0, '0);

        // random phases; sender idle rate steps 11, 59, then zero percent
        run_phase(14'd97, 120);
        run_phase(14'd0, 20);
        run_phase(14'd1, 20);
        idle_pct = 59;
        run_phase(14'd2, 30);
        run_phase(pst_pkg::LimitMax, 30);
        run_phase(14'd5461, 100);
        idle_pct = 0;
        run_phase(14'($urandom_range(3, 3000)), 130);
        run_phase(14'd10922, 130);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d builds, %0d reads, %0d tests, %0d no-ops",
                 cmd_tally[pst_pkg::CMD_BUILD], cmd_tally[pst_pkg::CMD_READ],
                 cmd_tally[pst_pkg::CMD_TEST], cmd_tally[pst_pkg::CMD_NOP]);
        $display("sieve limits from 0 to 16383, gap rates 11, 59 and 0 percent");
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
